>>> sv/dedt_pkg.sv
`default_nettype none
package dedt_pkg;

	localparam int MAX_SLOTS_DEF = 8;
	localparam int RESULT_LIMIT  = 8;
	localparam int EW            = $clog2(RESULT_LIMIT + 1);

	typedef enum logic {
		OP_SCHEDULE = 1'b0,
		OP_TICK     = 1'b1
	} op_t;

	typedef struct packed {
		op_t         operation;
		logic [7:0]  target_id;
		logic [7:0]  event_id;
		logic [31:0] delay_ms;
		logic [31:0] now_ms;
	} item_t;

	typedef struct packed {
		logic [7:0] out_target;
		logic [7:0] out_event;
		logic       last_of_run;
	} result_t;

	typedef struct packed {
		logic [7:0]  tgt;
		logic [7:0]  evt;
		logic [31:0] count;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_APPEND,
		S_TICK,
		S_FIN
	} state_t;

	typedef enum logic [1:0] {
		RD_ZERO,
		RD_NEXT,
		RD_LAST
	} rsel_t;

	typedef enum logic {
		WA_K,
		WA_N
	} wsel_t;

	typedef enum logic {
		WD_ITEM,
		WD_DEC
	} dsel_t;

	typedef enum logic {
		ES_SLOT,
		ES_ITEM
	} esrc_t;

	typedef struct packed {
		logic  load;
		logic  rd_en;
		rsel_t rsel;
		logic  wr_en;
		wsel_t wsel;
		dsel_t dsel;
		logic  k_inc;
		logic  n_inc;
		logic  n_dec;
		logic  emit;
		esrc_t esrc;
		logic  flush;
	} cmd_t;

	typedef struct packed {
		logic in_tick;
		logic in_dt_zero;
		logic n_zero;
		logic full;
		logic at_last;
		logic match;
		logic cnt_gt;
		logic cnt_nz;
		logic emit_ok;
		logic out_free;
		logic hold_valid;
	} sts_t;

endpackage
`default_nettype wire

>>> sv/dedt_ram.sv
`default_nettype none
module dedt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic                                    re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> sv/dedt_ctrl.sv
`default_nettype none
module dedt_ctrl
	import dedt_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic item_valid,
	input  wire sts_t sts,
	output cmd_t      cmd,
	output logic      busy
);

	state_t st_q, st_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
		end else begin
			st_q <= st_nxt;
		end
	end

	assign busy = (st_q != S_IDLE);

	always_comb begin
		st_nxt = st_q;
		cmd    = '0;
		unique case (st_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.load  = 1'b1;
					cmd.rd_en = 1'b1;
					cmd.rsel  = RD_ZERO;
					if (sts.in_tick) begin
						if (!sts.in_dt_zero && !sts.n_zero) begin
							st_nxt = S_TICK;
						end
					end else if (sts.n_zero) begin
						st_nxt = S_APPEND;
					end else begin
						st_nxt = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (sts.match) begin
					cmd.wr_en = 1'b1;
					cmd.wsel  = WA_K;
					cmd.dsel  = WD_ITEM;
					st_nxt    = S_IDLE;
				end else if (sts.at_last) begin
					if (sts.full) begin
						cmd.emit = 1'b1;
						cmd.esrc = ES_ITEM;
						st_nxt   = S_FIN;
					end else begin
						cmd.wr_en = 1'b1;
						cmd.wsel  = WA_N;
						cmd.dsel  = WD_ITEM;
						cmd.n_inc = 1'b1;
						st_nxt    = S_IDLE;
					end
				end else begin
					cmd.k_inc = 1'b1;
					cmd.rd_en = 1'b1;
					cmd.rsel  = RD_NEXT;
				end
			end
			S_APPEND: begin
				cmd.wr_en = 1'b1;
				cmd.wsel  = WA_N;
				cmd.dsel  = WD_ITEM;
				cmd.n_inc = 1'b1;
				st_nxt    = S_IDLE;
			end
			S_TICK: begin
				if (sts.cnt_gt) begin
					cmd.wr_en = 1'b1;
					cmd.wsel  = WA_K;
					cmd.dsel  = WD_DEC;
					if (sts.at_last) begin
						st_nxt = S_FIN;
					end else begin
						cmd.k_inc = 1'b1;
						cmd.rd_en = 1'b1;
						cmd.rsel  = RD_NEXT;
					end
				end else if (sts.emit_ok || !sts.cnt_nz) begin
					cmd.emit  = sts.cnt_nz;
					cmd.esrc  = ES_SLOT;
					cmd.n_dec = 1'b1;
					if (sts.at_last) begin
						st_nxt = S_FIN;
					end else begin
						cmd.rd_en = 1'b1;
						cmd.rsel  = RD_LAST;
					end
				end
			end
			S_FIN: begin
				if (!sts.hold_valid) begin
					st_nxt = S_IDLE;
				end else if (sts.out_free) begin
					cmd.flush = 1'b1;
					st_nxt    = S_IDLE;
				end
			end
			default: begin
				st_nxt = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

>>> sv/dedt_dp.sv
`default_nettype none
module dedt_dp
	import dedt_pkg::*;
#(
	parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire item_t   item,
	input  wire logic    result_stall,
	input  wire cmd_t    cmd,
	output sts_t         sts,
	output logic         result_valid,
	output result_t      result
);

	localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CW = $clog2(MAX_SLOTS + 1);

	item_t         item_q;
	logic [31:0]   last_time_q;
	logic [31:0]   dt_q;
	logic [IW-1:0] k_q;
	logic [CW-1:0] n_q;
	logic [EW-1:0] e_q;
	logic          hold_valid_q;
	logic [7:0]    hold_tgt_q;
	logic [7:0]    hold_evt_q;
	logic          res_valid_q;
	result_t       res_q;

	entry_t        rdata;
	entry_t        wdata;
	logic [IW-1:0] raddr;
	logic [IW-1:0] waddr;
	logic [CW-1:0] k_next;
	logic          out_free;
	logic          e_full;
	logic          do_emit;
	logic [7:0]    src_tgt;
	logic [7:0]    src_evt;
	logic [31:0]   dt_in;

	dedt_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (MAX_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (cmd.wr_en),
		.waddr (waddr),
		.wdata (wdata),
		.re    (cmd.rd_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign k_next   = CW'(k_q) + CW'(1);
	assign dt_in    = item.now_ms - last_time_q;
	assign out_free = !res_valid_q || !result_stall;
	assign e_full   = (e_q >= EW'(RESULT_LIMIT));
	assign do_emit  = cmd.emit && !e_full;

	always_comb begin
		unique case (cmd.rsel)
			RD_ZERO: raddr = '0;
			RD_NEXT: raddr = IW'(k_next);
			RD_LAST: raddr = IW'(n_q - CW'(1));
			default: raddr = '0;
		endcase
	end

	always_comb begin
		unique case (cmd.wsel)
			WA_K:    waddr = k_q;
			WA_N:    waddr = IW'(n_q);
			default: waddr = k_q;
		endcase
	end

	always_comb begin
		unique case (cmd.dsel)
			WD_ITEM: wdata = '{tgt: item_q.target_id, evt: item_q.event_id,
			                   count: item_q.delay_ms};
			WD_DEC:  wdata = '{tgt: rdata.tgt, evt: rdata.evt,
			                   count: rdata.count - dt_q};
			default: wdata = '{tgt: item_q.target_id, evt: item_q.event_id,
			                   count: item_q.delay_ms};
		endcase
	end

	always_comb begin
		unique case (cmd.esrc)
			ES_SLOT: begin
				src_tgt = rdata.tgt;
				src_evt = rdata.evt;
			end
			ES_ITEM: begin
				src_tgt = item_q.target_id;
				src_evt = item_q.event_id;
			end
			default: begin
				src_tgt = rdata.tgt;
				src_evt = rdata.evt;
			end
		endcase
	end

	always_comb begin
		sts.in_tick    = (item.operation == OP_TICK);
		sts.in_dt_zero = (dt_in == 32'd0);
		sts.n_zero     = (n_q == '0);
		sts.full       = (n_q == CW'(MAX_SLOTS));
		sts.at_last    = (k_next == n_q);
		sts.match      = (rdata.tgt == item_q.target_id) && (rdata.evt == item_q.event_id);
		sts.cnt_gt     = (rdata.count > dt_q);
		sts.cnt_nz     = (rdata.count != 32'd0);
		sts.emit_ok    = e_full || !hold_valid_q || out_free;
		sts.out_free   = out_free;
		sts.hold_valid = hold_valid_q;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q  <= '0;
			k_q          <= '0;
			n_q          <= '0;
			e_q          <= '0;
			hold_valid_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				k_q <= '0;
				e_q <= '0;
				if (item.operation == OP_TICK && dt_in != 32'd0) begin
					last_time_q <= item.now_ms;
				end
			end else begin
				if (cmd.k_inc) begin
					k_q <= IW'(k_next);
				end
				if (do_emit) begin
					e_q <= e_q + EW'(1);
				end
			end
			if (cmd.n_inc) begin
				n_q <= n_q + CW'(1);
			end else if (cmd.n_dec) begin
				n_q <= n_q - CW'(1);
			end
			if (do_emit) begin
				hold_valid_q <= 1'b1;
			end else if (cmd.flush) begin
				hold_valid_q <= 1'b0;
			end
			if ((do_emit && hold_valid_q) || cmd.flush) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
			dt_q   <= dt_in;
		end
		if (do_emit) begin
			hold_tgt_q <= src_tgt;
			hold_evt_q <= src_evt;
		end
		if (do_emit && hold_valid_q) begin
			res_q <= '{out_target: hold_tgt_q, out_event: hold_evt_q, last_of_run: 1'b0};
		end else if (cmd.flush) begin
			res_q <= '{out_target: hold_tgt_q, out_event: hold_evt_q, last_of_run: 1'b1};
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule
`default_nettype wire

>>> sv/delayed_event_dispatch_table.sv
`default_nettype none
// Table of up to MAX_SLOTS pending delayed events held in one single-port-read
// RAM, walked one entry per cycle unless result_stall holds off a result beat.
// A schedule beat on an empty table appends without comparing; otherwise it
// compares entries through the RAM read port until a match or the end; a full
// table with no match adds a closing state that waits while result_stall
// holds off the result beat. A tick beat whose time equals the last tick, or
// that finds the table empty, leaves it alone; otherwise each entry is kept or
// removed, then a closing state waits while result_stall holds off a result.
// Results of one beat come out in walk order (a removed slot is refilled from
// the last entry), the last one flagged by last_of_run; at most eight results
// per beat are delivered.
module delayed_event_dispatch_table
	import dedt_pkg::*;
#(
	parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	output logic         item_stall,
	input  wire item_t   item,
	output logic         result_valid,
	input  wire logic    result_stall,
	output result_t      result
);

	cmd_t cmd;
	sts_t sts;
	logic busy;

	dedt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.sts        (sts),
		.cmd        (cmd),
		.busy       (busy)
	);

	dedt_dp #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.result_stall (result_stall),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result       (result)
	);

	assign item_stall = busy;

endmodule
`default_nettype wire

>>> sv/dedt_checker.sv
`default_nettype none
module dedt_checker
	import dedt_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    item_valid,
	input wire logic    item_stall,
	input wire item_t   item,
	input wire logic    result_valid,
	input wire logic    result_stall,
	input wire result_t result
);

	// held result beat stays
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result beat dropped under stall");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("result payload changed under stall");

	// a schedule always walks or writes the table
	a_sched_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.operation == OP_SCHEDULE |=> item_stall)
		else $error("schedule beat finished in one cycle");

	// a run is still open while a non-final result is shown
	a_run_open: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last_of_run |-> item_stall)
		else $error("new beat taken before run closed");

endmodule

bind delayed_event_dispatch_table dedt_checker u_dedt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
`default_nettype wire
